// File: rtl/tsf_pkg.sv
// Shared types, codes and widths for the triangle span generator.
package tsf_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int COLOUR_W       = 16;
  localparam int SPAN_LEN_W     = 17;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SPAN = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FLAT  = 2'd1,
    PH_UPPER = 2'd2,
    PH_LOWER = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT0,
    ST_SORT1,
    ST_SORT2,
    ST_SETUP,
    ST_DSTART,
    ST_DIV,
    ST_EMIT,
    ST_LOWER
  } state_t;

  typedef struct packed {
    logic                       kind;
    logic signed [FIELD_W-1:0]  ax;
    logic signed [FIELD_W-1:0]  ay;
    logic signed [FIELD_W-1:0]  bx;
    logic signed [FIELD_W-1:0]  by;
    logic signed [FIELD_W-1:0]  cx;
    logic signed [FIELD_W-1:0]  cy;
    logic [COLOUR_W-1:0]        fill;
  } in_item_t;

  typedef struct packed {
    logic                       span_valid;
    logic signed [FIELD_W-1:0]  span_x;
    logic signed [FIELD_W-1:0]  span_row;
    logic [SPAN_LEN_W-1:0]      span_length;
    logic [COLOUR_W-1:0]        span_colour;
    logic                       last_span;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic swap_lo;
    logic swap_hi;
    logic setup;
    logic div_start;
    logic emit;
    logic enter_lower;
  } ctrl_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   div_done;
    logic   out_free;
  } dp_stat_t;

endpackage

// File: rtl/tsf_in_if.sv
// Input channel: triangle load or next-span request transactions.
interface tsf_in_if;
  import tsf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [FIELD_W-1:0] ax;
  logic signed [FIELD_W-1:0] ay;
  logic signed [FIELD_W-1:0] bx;
  logic signed [FIELD_W-1:0] by;
  logic signed [FIELD_W-1:0] cx;
  logic signed [FIELD_W-1:0] cy;
  logic [COLOUR_W-1:0]       fill;

  modport source (output valid, kind, ax, ay, bx, by, cx, cy, fill, input ready);
  modport sink   (input valid, kind, ax, ay, bx, by, cx, cy, fill, output ready);
endinterface

// File: rtl/tsf_out_if.sv
// Result channel: one span transaction per request.
interface tsf_out_if;
  import tsf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      span_valid;
  logic signed [FIELD_W-1:0] span_x;
  logic signed [FIELD_W-1:0] span_row;
  logic [SPAN_LEN_W-1:0]     span_length;
  logic [COLOUR_W-1:0]       span_colour;
  logic                      last_span;

  modport source (output valid, span_valid, span_x, span_row, span_length, span_colour,
                  last_span, input ready);
  modport sink   (input valid, span_valid, span_x, span_row, span_length, span_colour,
                  last_span, output ready);
endinterface

// File: rtl/triangle_scanline_fill.sv
// Top level of the filled-triangle span generator.
// Load transaction: accept, three compare-swap sort steps, setup, edge entry.
// Span request: divider start, division wait, emit, edge entry; the dividers give one quotient bit per cycle.
// Request with no triangle pending, or for a flat triangle: goes straight to the emit step, with no division.
// One transaction is in flight at a time; a finished span waits in the output register.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any pending triangle.
module triangle_scanline_fill #(
  parameter int COORD_BITS = tsf_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tsf_in_if.sink     in_if,
  tsf_out_if.source  out_if
);
  import tsf_pkg::*;

  in_item_t   in_item;
  out_item_t  out_item;
  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  state_t     state;
  logic       out_valid;
  logic       in_ready;

  // pack the input transaction for the datapath
  assign in_item.kind = in_if.kind;
  assign in_item.ax   = in_if.ax;
  assign in_item.ay   = in_if.ay;
  assign in_item.bx   = in_if.bx;
  assign in_item.by   = in_if.by;
  assign in_item.cx   = in_if.cx;
  assign in_item.cy   = in_if.cy;
  assign in_item.fill = in_if.fill;

  // sequencer: accepts only when idle, steps the datapath through each transaction
  tsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_kind  (in_if.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  // datapath: vertex sort, edge accumulators, two dividers, span output register
  tsf_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .out_item  (out_item)
  );

  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid;
  assign out_if.span_valid  = out_item.span_valid;
  assign out_if.span_x      = out_item.span_x;
  assign out_if.span_row    = out_item.span_row;
  assign out_if.span_length = out_item.span_length;
  assign out_if.span_colour = out_item.span_colour;
  assign out_if.last_span   = out_item.last_span;

  // a span is only written when the output register is free or draining
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> stat.out_free)
    else $error("span written over an untaken result");

  // one transaction at a time: no accept right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second transaction accepted while busy");

  // dividers finish only while the sequencer waits for them
  assert property (@(posedge clk) disable iff (!rst_n) stat.div_done |-> (state == ST_DIV))
    else $error("divider result outside the wait step");

  // a result appears only from an emit step
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_if.valid) |-> $past(cmd.emit))
    else $error("result valid without an emit");
endmodule

// File: rtl/tsf_div.sv
// Radix-2 restoring divider: signed dividend, nonnegative divisor, truncates toward zero.
module tsf_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 17,
  parameter int Q_W   = 18
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [Q_W-1:0]   quo
);
  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] dvd_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic             zero_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_nxt;
  logic [NUM_W-1:0] q_signed;

  assign num_mag = num[NUM_W-1] ? (-num) : num;
  assign rem_sh  = {rem_r, dvd_r[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == '0)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= num_mag;
      rem_r  <= '0;
      den_r  <= den;
      neg_r  <= num[NUM_W-1];
      zero_r <= (den == '0);
      cnt_r  <= CNT_W'(NUM_W - 1);
    end else if (run_r) begin
      // remainder stays below the divisor, so its top bit is always clear
      rem_r <= rem_nxt[DEN_W-1:0];
      dvd_r <= {dvd_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign q_signed = neg_r ? (-dvd_r) : dvd_r;
  assign quo      = zero_r ? '0 : Q_W'(signed'(q_signed));
  assign done     = done_r;
endmodule

// File: rtl/tsf_ctrl.sv
// Sequencer: load/sort/setup, span division and emit steps.
module tsf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  input  tsf_pkg::dp_stat_t   stat,
  output tsf_pkg::ctrl_cmd_t  cmd,
  output tsf_pkg::state_t     state
);
  import tsf_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            state_nxt = ST_SORT0;
          end else if (stat.phase inside {PH_UPPER, PH_LOWER}) begin
            state_nxt = ST_DSTART;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SORT0:  state_nxt = ST_SORT1;
      ST_SORT1:  state_nxt = ST_SORT2;
      ST_SORT2:  state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = ST_LOWER;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = ST_LOWER;
        end
      end
      ST_LOWER:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = accept && (in_kind == KIND_LOAD);
      end
      ST_SORT0:  cmd.swap_lo     = 1'b1;
      ST_SORT1:  cmd.swap_hi     = 1'b1;
      ST_SORT2:  cmd.swap_lo     = 1'b1;
      ST_SETUP:  cmd.setup       = 1'b1;
      ST_DSTART: cmd.div_start   = 1'b1;
      ST_DIV:    cmd             = '0;
      ST_EMIT:   cmd.emit        = stat.out_free;
      ST_LOWER:  cmd.enter_lower = 1'b1;
      default:   cmd             = '0;
    endcase
  end

  assign state = state_r;
endmodule

// File: rtl/tsf_dp.sv
// Datapath: sorted vertices, edge accumulators, dividers and output register.
module tsf_dp #(
  parameter int COORD_BITS = tsf_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tsf_pkg::in_item_t   in_item,
  input  tsf_pkg::ctrl_cmd_t  cmd,
  output tsf_pkg::dp_stat_t   stat,
  output logic                out_valid,
  input  logic                out_ready,
  output tsf_pkg::out_item_t  out_item
);
  import tsf_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int D_W   = CB + 1;
  localparam int ACC_W = 2 * CB + 2;
  localparam int Q_W   = CB + 2;
  localparam int E_W   = CB + 3;

  logic signed [CB-1:0]    sx_r [3];
  logic signed [CB-1:0]    sy_r [3];
  logic [COLOUR_W-1:0]     colour_r;
  logic signed [D_W-1:0]   row_r;
  logic signed [D_W-1:0]   uer_r;
  logic signed [ACC_W-1:0] acc_a_r;
  logic signed [ACC_W-1:0] acc_b_r;
  phase_t                  phase_r;
  logic                    pend_r;
  logic                    o_valid_r;
  out_item_t               o_item_r;

  // widened vertex values and edge deltas
  logic signed [D_W-1:0] x0e, x1e, x2e, y0e, y1e, y2e;
  logic signed [D_W-1:0] dx01, dx12, dx02, dy01, dy12, dy02;
  assign x0e  = D_W'(sx_r[0]);
  assign x1e  = D_W'(sx_r[1]);
  assign x2e  = D_W'(sx_r[2]);
  assign y0e  = D_W'(sy_r[0]);
  assign y1e  = D_W'(sy_r[1]);
  assign y2e  = D_W'(sy_r[2]);
  assign dx01 = x1e - x0e;
  assign dx12 = x2e - x1e;
  assign dx02 = x2e - x0e;
  assign dy01 = y1e - y0e;
  assign dy12 = y2e - y1e;
  assign dy02 = y2e - y0e;

  logic is_upper;
  assign is_upper = (phase_r == PH_UPPER);

  // dividers; edge heights are nonnegative after sorting
  logic                  done_a, done_b;
  logic signed [Q_W-1:0] qa, qb;
  logic [D_W-1:0]        den_a;
  assign den_a = is_upper ? dy01 : dy12;

  tsf_div #(.NUM_W(ACC_W), .DEN_W(D_W), .Q_W(Q_W)) u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (acc_a_r),
    .den   (den_a),
    .done  (done_a),
    .quo   (qa)
  );

  tsf_div #(.NUM_W(ACC_W), .DEN_W(D_W), .Q_W(Q_W)) u_div_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (acc_b_r),
    .den   (dy02),
    .done  (done_b),
    .quo   (qb)
  );

  // setup
  logic signed [D_W-1:0] uer_nxt;
  assign uer_nxt = (sy_r[1] == sy_r[2]) ? y1e : (y1e - D_W'(1));

  // entry to the lower part
  logic signed [ACC_W-1:0] prod_a, prod_b;
  assign prod_a = ACC_W'(dx12) * ACC_W'(row_r - y1e);
  assign prod_b = ACC_W'(dx02) * ACC_W'(row_r - y0e);

  // span endpoints
  logic signed [E_W-1:0] a_e, b_e, lo_e, hi_e;
  logic signed [CB-1:0]  fmin01, fmax01, fmin, fmax;
  logic signed [E_W-1:0] span_lo, span_hi;
  logic signed [E_W:0]   len_v;
  logic                  last_v;
  logic signed [D_W-1:0] row_nxt;
  logic signed [D_W-1:0] dx_a;

  assign a_e    = (is_upper ? E_W'(x0e) : E_W'(x1e)) + E_W'(qa);
  assign b_e    = E_W'(x0e) + E_W'(qb);
  assign lo_e   = (a_e > b_e) ? b_e : a_e;
  assign hi_e   = (a_e > b_e) ? a_e : b_e;
  assign fmin01 = (sx_r[1] < sx_r[0]) ? sx_r[1] : sx_r[0];
  assign fmax01 = (sx_r[1] > sx_r[0]) ? sx_r[1] : sx_r[0];
  assign fmin   = (sx_r[2] < fmin01) ? sx_r[2] : fmin01;
  assign fmax   = (sx_r[2] > fmax01) ? sx_r[2] : fmax01;
  assign last_v = (row_r >= y2e);
  assign row_nxt = row_r + D_W'(1);
  assign dx_a   = is_upper ? dx01 : dx12;

  always_comb begin
    if (phase_r == PH_FLAT) begin
      span_lo = E_W'(fmin);
      span_hi = E_W'(fmax);
    end else begin
      span_lo = lo_e;
      span_hi = hi_e;
    end
  end
  assign len_v = (E_W + 1)'(span_hi) - (E_W + 1)'(span_lo) + (E_W + 1)'(1);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pend_r    <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end

      if (cmd.load) begin
        phase_r <= PH_IDLE;
        pend_r  <= 1'b0;
      end else if (cmd.setup) begin
        if (sy_r[0] == sy_r[2]) begin
          phase_r <= PH_FLAT;
          pend_r  <= 1'b0;
        end else if (y0e <= uer_nxt) begin
          phase_r <= PH_UPPER;
          pend_r  <= 1'b0;
        end else begin
          phase_r <= PH_LOWER;
          pend_r  <= 1'b1;
        end
      end else if (cmd.enter_lower) begin
        pend_r <= 1'b0;
      end else if (cmd.emit) begin
        if (phase_r == PH_FLAT) begin
          phase_r <= PH_IDLE;
        end else if (phase_r inside {PH_UPPER, PH_LOWER}) begin
          if (last_v) begin
            phase_r <= PH_IDLE;
          end else if (is_upper && (row_nxt > uer_r)) begin
            phase_r <= PH_LOWER;
            pend_r  <= 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r[0]  <= in_item.ax[CB-1:0];
      sy_r[0]  <= in_item.ay[CB-1:0];
      sx_r[1]  <= in_item.bx[CB-1:0];
      sy_r[1]  <= in_item.by[CB-1:0];
      sx_r[2]  <= in_item.cx[CB-1:0];
      sy_r[2]  <= in_item.cy[CB-1:0];
      colour_r <= in_item.fill;
    end else if (cmd.swap_lo && (sy_r[0] > sy_r[1])) begin
      sx_r[0] <= sx_r[1];
      sy_r[0] <= sy_r[1];
      sx_r[1] <= sx_r[0];
      sy_r[1] <= sy_r[0];
    end else if (cmd.swap_hi && (sy_r[1] > sy_r[2])) begin
      sx_r[1] <= sx_r[2];
      sy_r[1] <= sy_r[2];
      sx_r[2] <= sx_r[1];
      sy_r[2] <= sy_r[1];
    end

    if (cmd.setup) begin
      row_r   <= y0e;
      acc_a_r <= '0;
      acc_b_r <= '0;
      uer_r   <= (sy_r[0] == sy_r[2]) ? y0e : uer_nxt;
    end else if (cmd.enter_lower && pend_r) begin
      acc_a_r <= prod_a;
      acc_b_r <= prod_b;
    end else if (cmd.emit && (phase_r inside {PH_UPPER, PH_LOWER})) begin
      acc_a_r <= acc_a_r + ACC_W'(dx_a);
      acc_b_r <= acc_b_r + ACC_W'(dx02);
      if (!last_v) begin
        row_r <= row_nxt;
      end
    end

    if (cmd.emit) begin
      if (phase_r == PH_IDLE) begin
        o_item_r <= '0;
      end else begin
        o_item_r.span_valid  <= 1'b1;
        o_item_r.span_x      <= FIELD_W'(span_lo);
        o_item_r.span_row    <= (phase_r == PH_FLAT) ? FIELD_W'(y0e) : FIELD_W'(row_r);
        o_item_r.span_length <= SPAN_LEN_W'(len_v);
        o_item_r.span_colour <= colour_r;
        o_item_r.last_span   <= (phase_r == PH_FLAT) ? 1'b1 : last_v;
      end
    end
  end

  assign stat.phase    = phase_r;
  assign stat.div_done = done_a && done_b;
  assign stat.out_free = !o_valid_r || out_ready;
  assign out_valid     = o_valid_r;
  assign out_item      = o_item_r;
endmodule
